FILE: hw/rtl/utf8d_pkg.sv
// Shared types, constants and lookup tables for the UTF-8 decoder.
package utf8d_pkg;

    localparam int BYTE_W  = 8;
    localparam int STATE_W = 4;
    localparam int CLASS_W = 4;
    localparam int CP_W    = 21;
    localparam int STAT_W  = 2;
    localparam int ST_NUM  = 9;
    localparam int CLS_NUM = 16;

    localparam logic [STATE_W-1:0] S_ACCEPT = 4'd0;
    localparam logic [STATE_W-1:0] S_REJECT = 4'd1;
    localparam logic [STATE_W-1:0] S_LAST   = 4'd8;

    localparam logic [STAT_W-1:0] STATUS_COMPLETE = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_REJECT   = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_MORE     = 2'd2;

    localparam logic [5:0]        CONT_MASK = 6'h3f;
    localparam logic [BYTE_W-1:0] LEAD_MASK = 8'hff;

    localparam logic [STATE_W-1:0] NEXT_STATE [0:ST_NUM-1][0:CLS_NUM-1] = '{
        '{4'd0,4'd1,4'd2,4'd3,4'd5,4'd8,4'd7,4'd1,4'd1,4'd1,4'd4,4'd6,4'd1,4'd1,4'd1,4'd1},
        '{4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
        '{4'd1,4'd0,4'd1,4'd1,4'd1,4'd1,4'd1,4'd0,4'd1,4'd0,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
        '{4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd2,4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
        '{4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
        '{4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
        '{4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd3,4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
        '{4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd3,4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
        '{4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1}
    };

    typedef struct packed {
        logic [STATE_W-1:0] state;
        logic [CP_W-1:0]    acc;
        logic [STAT_W-1:0]  status;
    } t_step;

    function automatic logic [CLASS_W-1:0] byte_class(input logic [BYTE_W-1:0] b);
        logic [CLASS_W-1:0] c;
        unique case (b) inside
            [8'h00:8'h7f]: c = 4'd0;
            [8'h80:8'h8f]: c = 4'd1;
            [8'h90:8'h9f]: c = 4'd9;
            [8'ha0:8'hbf]: c = 4'd7;
            8'hc0, 8'hc1:  c = 4'd8;
            [8'hc2:8'hdf]: c = 4'd2;
            8'he0:         c = 4'd10;
            8'hed:         c = 4'd4;
            [8'he1:8'hec],
            8'hee, 8'hef:  c = 4'd3;
            8'hf0:         c = 4'd11;
            [8'hf1:8'hf3]: c = 4'd6;
            8'hf4:         c = 4'd5;
            default:       c = 4'd8;
        endcase
        return c;
    endfunction

endpackage

FILE: hw/rtl/utf8d_step.sv
// Next-state, accumulator and status logic for one byte.
module utf8d_step
    import utf8d_pkg::*;
(
    input  logic [STATE_W-1:0] i_state,
    input  logic [CP_W-1:0]    i_acc,
    input  logic [BYTE_W-1:0]  i_byte,
    input  logic               i_start,
    output t_step              o_step
);

    logic [CLASS_W-1:0] cls;
    logic [STATE_W-1:0] cur;
    logic [STATE_W-1:0] nxt;
    logic [BYTE_W-1:0]  lead;

    always_comb begin
        cls  = byte_class(i_byte);
        cur  = i_start ? S_ACCEPT : i_state;
        if (cur > S_LAST) begin
            cur = S_REJECT;
        end
        nxt  = NEXT_STATE[cur][cls];
        lead = (LEAD_MASK >> cls) & i_byte;

        o_step.state = nxt;
        if (cur != S_ACCEPT) begin
            o_step.acc = {i_acc[CP_W-7:0], i_byte[5:0] & CONT_MASK};
        end else begin
            o_step.acc = {{(CP_W-BYTE_W){1'b0}}, lead};
        end

        if (nxt == S_ACCEPT) begin
            o_step.status = STATUS_COMPLETE;
        end else if (nxt == S_REJECT) begin
            o_step.status = STATUS_REJECT;
        end else begin
            o_step.status = STATUS_MORE;
        end
    end

endmodule

FILE: hw/rtl/utf8_dfa_decoder_core.sv
// UTF-8 stream decoder core: decoder state, result register and handshake.
//
// Takes one byte per cycle and gives one result per byte, in the cycle after the
// byte is taken. Each result carries the accumulated codepoint and a status
// (complete, rejected, more bytes needed); the codepoint is valid only when
// the status is complete. A rejected sequence stays rejected until a byte
// arrives with start_of_text set, which also drops any open sequence. The
// rate of one byte per cycle is set by the state feedback loop through the
// byte class and transition lookups; a new byte is taken in the same cycle
// as the held result is taken, so the input stalls only while the output stalls.
module utf8_dfa_decoder_core
    import utf8d_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_axis_tuser,   // [0] start_of_text
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [20:0] codepoint, [23:21] zero
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    logic [STATE_W-1:0] r_state;
    logic [CP_W-1:0]    r_acc;
    logic               r_out_valid;
    logic [STAT_W-1:0]  r_status;
    logic               in_xfer;
    t_step              n_step;

    utf8d_step u_step (
        .i_state (r_state),
        .i_acc   (r_acc),
        .i_byte  (s_axis_tdata),
        .i_start (s_axis_tuser[0]),
        .o_step  (n_step)
    );

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_ACCEPT;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
            r_status    <= STATUS_COMPLETE;
        end else begin
            if (in_xfer) begin
                r_state  <= n_step.state;
                r_acc    <= n_step.acc;
                r_status <= n_step.status;
            end
            if (in_xfer) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(24-CP_W){1'b0}}, r_acc};
    assign m_axis_tuser  = r_status;

    a_state_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state <= S_LAST)
        else $error("decoder state out of range");

    a_reject_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && !s_axis_tuser[0] && r_state == S_REJECT) |=> (r_state == S_REJECT))
        else $error("reject state not sticky");

    a_status_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == STATUS_COMPLETE) |-> (r_state == S_ACCEPT))
        else $error("complete status without accept state");

    a_ascii: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && !s_axis_tdata[7] && (s_axis_tuser[0] || r_state == S_ACCEPT))
        |=> (r_status == STATUS_COMPLETE
             && r_acc == {{(CP_W-BYTE_W){1'b0}}, $past(s_axis_tdata)}))
        else $error("ASCII byte not decoded directly");

endmodule

FILE: tb/utf8_dfa_decoder_core_checker.sv
// Stream monitor for the UTF-8 decoder: predicts each result and compares it.
module utf8_dfa_decoder_core_checker
    import utf8d_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic [0:0]  i_s_tuser,   // [0] start_of_text
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,   // [20:0] codepoint, [23:21] zero
    input  logic [1:0]  i_m_tuser,   // [1:0] status
    output int          o_fail_count,
    output int          o_pending,
    output int          o_n_bytes,
    output int          o_n_complete,
    output int          o_n_reject,
    output int          o_n_more
);

    typedef struct packed {
        logic [CP_W-1:0]   cp;
        logic [STAT_W-1:0] status;
    } t_decoded;

    localparam logic [STATE_W-1:0] STEP_TABLE [0:8][0:15] = '{
        '{0,1,2,3,5,8,7,1,1,1,4,6,1,1,1,1},
        '{1,1,1,1,1,1,1,1,1,1,1,1,1,1,1,1},
        '{1,0,1,1,1,1,1,0,1,0,1,1,1,1,1,1},
        '{1,2,1,1,1,1,1,2,1,2,1,1,1,1,1,1},
        '{1,1,1,1,1,1,1,2,1,1,1,1,1,1,1,1},
        '{1,2,1,1,1,1,1,1,1,2,1,1,1,1,1,1},
        '{1,1,1,1,1,1,1,3,1,3,1,1,1,1,1,1},
        '{1,3,1,1,1,1,1,3,1,3,1,1,1,1,1,1},
        '{1,3,1,1,1,1,1,1,1,1,1,1,1,1,1,1}
    };

    logic [STATE_W-1:0] dfa_st;
    logic [CP_W-1:0]    cp_acc;
    t_decoded           cp_expected_q [$];
    int                 fail_count = 0;
    int                 n_bytes = 0;
    int                 n_complete = 0;
    int                 n_reject = 0;
    int                 n_more = 0;

    assign o_fail_count = fail_count;
    assign o_n_bytes    = n_bytes;
    assign o_n_complete = n_complete;
    assign o_n_reject   = n_reject;
    assign o_n_more     = n_more;

    initial o_pending = 0;

    function automatic logic [3:0] utf8_class_of(input logic [7:0] b);
        if (b < 8'h80)       return 4'd0;
        else if (b < 8'h90)  return 4'd1;
        else if (b < 8'ha0)  return 4'd9;
        else if (b < 8'hc0)  return 4'd7;
        else if (b < 8'hc2)  return 4'd8;
        else if (b < 8'he0)  return 4'd2;
        else if (b == 8'he0) return 4'd10;
        else if (b == 8'hed) return 4'd4;
        else if (b < 8'hf0)  return 4'd3;
        else if (b == 8'hf0) return 4'd11;
        else if (b < 8'hf4)  return 4'd6;
        else if (b == 8'hf4) return 4'd5;
        else                 return 4'd8;
    endfunction

    function automatic t_decoded decode_byte(input logic [7:0] b, input logic sot);
        logic [3:0]         cls;
        logic [STATE_W-1:0] st;
        t_decoded           r;
        cls = utf8_class_of(b);
        st  = sot ? S_ACCEPT : dfa_st;
        if (st > S_LAST) st = S_REJECT;
        // open sequence (or sticky reject) shifts in payload; accept loads lead bits
        if (st != S_ACCEPT) cp_acc = {cp_acc[CP_W-7:0], b[5:0]};
        else cp_acc = CP_W'((LEAD_MASK >> cls) & b);
        dfa_st = STEP_TABLE[st][cls];
        r.cp = cp_acc;
        if (dfa_st == S_ACCEPT)      r.status = STATUS_COMPLETE;
        else if (dfa_st == S_REJECT) r.status = STATUS_REJECT;
        else                         r.status = STATUS_MORE;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_decoded want;
        t_decoded pred;
        if (!i_rst_n) begin
            dfa_st = S_ACCEPT;
            cp_acc = '0;
            cp_expected_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (cp_expected_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("ERROR: unexpected result transfer: codepoint %h status %0d",
                                 i_m_tdata, i_m_tuser);
                end else begin
                    want = cp_expected_q.pop_front();
                    if (i_m_tdata != {3'b000, want.cp} || i_m_tuser != want.status) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("ERROR: codepoint exp %h got %h, status exp %0d got %0d",
                                     {3'b000, want.cp}, i_m_tdata, want.status, i_m_tuser);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                pred = decode_byte(i_s_tdata, i_s_tuser[0]);
                cp_expected_q.push_back(pred);
                n_bytes++;
                case (pred.status)
                    STATUS_COMPLETE: n_complete++;
                    STATUS_REJECT:   n_reject++;
                    default:         n_more++;
                endcase
            end
        end
        o_pending <= cp_expected_q.size();
    end

endmodule

FILE: tb/utf8_dfa_decoder_core_tb.sv
// Top of the UTF-8 decoder testbench: clock, reset, byte stimulus and verdict.
module utf8_dfa_decoder_core_tb;

    localparam int N_ITEMS  = 1300;
    localparam int N_QUIET  = 1150;
    localparam int N_DRAIN  = 650;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] data_byte
    logic [0:0]  s_axis_tuser  = 1'b0;    // [0] start_of_text
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;            // [20:0] codepoint, [23:21] zero
    logic [1:0]  m_axis_tuser;            // [1:0] status

    int fail_count;
    int pending;
    int n_bytes;
    int n_complete;
    int n_reject;
    int n_more;
    int sent      = 0;
    int n_directed = 0;
    bit quiet_tail = 1'b0;
    bit tx_calm    = 1'b0;
    bit drained_once = 1'b0;

    utf8_dfa_decoder_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    utf8_dfa_decoder_core_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_n_bytes    (n_bytes),
        .o_n_complete (n_complete),
        .o_n_reject   (n_reject),
        .o_n_more     (n_more)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #1600000;
        $display("Test completed with failures");
        $finish;
    end

    // result side back-pressure
    initial begin
        forever begin
            @(posedge i_clk);
            if (!quiet_tail && $urandom_range(0, 9) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else if ($urandom_range(0, 9) == 0) begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(20, 60)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic send_transfer(input logic [7:0] b, input bit sot);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= sot;
        do @(posedge i_clk); while (!s_axis_tready);
        sent++;
        if (!quiet_tail && !tx_calm && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    // cut drops trailing bytes; corrupt replaces one continuation byte
    task automatic send_codepoint(input logic [20:0] cp, input bit sot, input int cut,
                                  input bit corrupt);
        logic [7:0] enc [4];
        int         n;
        if (cp < 21'h80) begin
            enc[0] = cp[7:0];
            n = 1;
        end else if (cp < 21'h800) begin
            enc[0] = {3'b110, cp[10:6]};
            enc[1] = {2'b10, cp[5:0]};
            n = 2;
        end else if (cp < 21'h10000) begin
            enc[0] = {4'b1110, cp[15:12]};
            enc[1] = {2'b10, cp[11:6]};
            enc[2] = {2'b10, cp[5:0]};
            n = 3;
        end else begin
            enc[0] = {5'b11110, cp[20:18]};
            enc[1] = {2'b10, cp[17:12]};
            enc[2] = {2'b10, cp[11:6]};
            enc[3] = {2'b10, cp[5:0]};
            n = 4;
        end
        if (corrupt && n > 1) enc[$urandom_range(1, n - 1)] = 8'($urandom_range(0, 255));
        if (cut >= n) cut = n - 1;
        for (int k = 0; k < n - cut; k++) send_transfer(enc[k], sot && k == 0);
    endtask

    function automatic logic [20:0] rand_codepoint();
        logic [20:0] cp;
        case ($urandom_range(1, 4))
            1: cp = 21'($urandom_range(0, 'h7f));
            2: cp = 21'($urandom_range('h80, 'h7ff));
            3: begin
                cp = 21'($urandom_range('h800, 'hffff));
                if (cp >= 21'hd800 && cp <= 21'hdfff) cp = cp ^ 21'h1000;
            end
            default: cp = 21'($urandom_range('h10000, 'h10ffff));
        endcase
        return cp;
    endfunction

    task automatic wait_drained();
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        int r;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_codepoint(21'h0, 1'b1, 0, 1'b0);
        send_codepoint(21'h7f, 1'b0, 0, 1'b0);
        send_codepoint(21'h80, 1'b0, 0, 1'b0);
        send_codepoint(21'h800, 1'b0, 0, 1'b0);
        send_codepoint(21'hd7ff, 1'b0, 0, 1'b0);
        send_codepoint(21'h10000, 1'b0, 0, 1'b0);
        send_codepoint(21'h10ffff, 1'b0, 0, 1'b0);
        send_transfer(8'hf1, 1'b0);
        send_transfer(8'he1, 1'b1);    // start drops the open sequence
        send_transfer(8'hff, 1'b0);
        send_transfer(8'h41, 1'b0);    // sticky reject
        send_transfer(8'hc0, 1'b1);    // overlong lead after restart
        n_directed = sent;

        while (sent < N_ITEMS) begin
            if (sent >= N_QUIET) quiet_tail = 1'b1;
            tx_calm = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 65) begin
                send_codepoint(rand_codepoint(), $urandom_range(0, 5) == 0, 0, 1'b0);
            end else if (r < 80) begin
                send_codepoint(rand_codepoint(), $urandom_range(0, 5) == 0,
                               $urandom_range(0, 2), 1'($urandom_range(0, 1)));
            end else if (r < 95) begin
                repeat ($urandom_range(1, 4))
                    send_transfer(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end else begin
                send_codepoint(21'($urandom_range('h80, 'h10ffff)), 1'b0, 1, 1'b0);
                send_codepoint(rand_codepoint(), 1'b1, 0, 1'b0);
            end
            if (!drained_once && sent >= N_DRAIN) begin
                drained_once = 1'b1;
                s_axis_tvalid <= 1'b0;
                wait_drained();
            end
        end
        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (10) @(posedge i_clk);

        $display("Run covered %0d bytes (%0d directed) with idling on both sides and a full drain",
                 n_bytes, n_directed);
        $display("Predicted results: %0d complete, %0d rejected, %0d awaiting more bytes",
                 n_complete, n_reject, n_more);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
